>>> hdl/dfod_pkg.sv
`timescale 1ns / 1ps

package dfod_pkg;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int FACE_W     = 3;
    localparam int MODE_W     = 2;
    localparam int TIMER_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int AXES       = 3;

    // Default block-averaging exponent (2^AVG_EXP samples per block)
    localparam int AVG_EXP_DEF = 3;

    // Input item kinds
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THROW_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD = 3'd4;

    // Configuration reset values
    localparam logic [8:0]         STILL_LIMIT_RST  = 9'd13;
    localparam logic [8:0]         FACE_LOW_RST     = 9'd242;
    localparam logic [9:0]         FACE_HIGH_RST    = 10'd269;
    localparam logic [TIMER_W-1:0] THROW_TIME_RST   = 16'd5000;
    localparam logic [TIMER_W-1:0] CHECK_PERIOD_RST = 16'd1000;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_MOVING = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_X  = 3'd6;
    localparam logic [FACE_W-1:0] FACE_POS_Y  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Y  = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Z  = 3'd5;

    typedef struct packed {
        logic [8:0]         still_limit;
        logic [8:0]         face_low;
        logic [9:0]         face_high;
        logic [TIMER_W-1:0] throw_time;
        logic [TIMER_W-1:0] check_period;
    } t_cfg;

    // What one axis lane reports about its current block mean
    typedef struct packed {
        logic still;
        logic up;
        logic neg;
    } t_lane_flags;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              face_found;
        logic              checking;
        logic              throw_running;
    } t_result;

endpackage

>>> hdl/dfod_in_if.sv
`timescale 1ns / 1ps

interface dfod_in_if import dfod_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;

    modport source (output valid, output mode, output sample_x, output sample_y,
                    output sample_z, input ready);
    modport sink (input valid, input mode, input sample_x, input sample_y,
                  input sample_z, output ready);
endinterface

>>> hdl/dfod_out_if.sv
`timescale 1ns / 1ps

interface dfod_out_if import dfod_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FACE_W-1:0] face;
    logic              face_found;
    logic              checking;
    logic              throw_running;

    modport source (output valid, output face, output face_found, output checking,
                    output throw_running, input ready);
    modport sink (input valid, input face, input face_found, input checking,
                  input throw_running, output ready);
endinterface

>>> hdl/dfod_axis_lane.sv
`timescale 1ns / 1ps

module dfod_axis_lane import dfod_pkg::*; #(
    parameter int AVG_EXP = AVG_EXP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_sample_en,
    input  logic                       i_block_end,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_cfg                       i_cfg,
    output t_lane_flags                o_flags
);

    localparam int SUM_W = SAMPLE_W + AVG_EXP;

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [SAMPLE_W-1:0]        w_mag;

    // Running block sum; the arithmetic shift by AVG_EXP is the top bits of the sum.
    assign n_sum = r_sum + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_mean <= '0;
        end else if (i_sample_en) begin
            if (i_block_end) begin
                r_mean <= n_sum[SUM_W-1 -: SAMPLE_W];
                r_sum  <= '0;
            end else begin
                r_sum <= n_sum;
            end
        end
    end

    // Magnitude of the mean; the most negative value maps to 512 as unsigned.
    assign w_mag = r_mean[SAMPLE_W-1] ? SAMPLE_W'(-r_mean) : SAMPLE_W'(r_mean);

    // Classify the axis against the still limit and the face window.
    always_comb begin
        o_flags.still = w_mag < {1'b0, i_cfg.still_limit};
        o_flags.up    = !o_flags.still && (w_mag > {1'b0, i_cfg.face_low})
                        && (w_mag < i_cfg.face_high);
        o_flags.neg   = r_mean[SAMPLE_W-1];
    end

endmodule

>>> hdl/dfod_ctrl.sv
`timescale 1ns / 1ps

module dfod_ctrl import dfod_pkg::*; #(
    parameter int AVG_EXP = AVG_EXP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [MODE_W-1:0] i_mode,
    input  t_lane_flags       i_flags [AXES],
    input  t_cfg              i_cfg,
    output logic              o_block_end,
    output t_result           o_result
);

    localparam int CNT_W = (AVG_EXP > 0) ? AVG_EXP : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVG_EXP) - 1);

    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TIMER_W-1:0] r_check_ticks, n_check_ticks;
    logic [TIMER_W-1:0] r_throw_ticks, n_throw_ticks;
    logic               r_check_armed, n_check_armed;
    logic               r_throw_armed, n_throw_armed;
    logic [FACE_W-1:0]  r_face, n_face;
    logic               w_found;
    logic [1:0]         w_still_cnt;
    logic [1:0]         w_up_cnt;
    logic               w_check_ok;
    logic [FACE_W-1:0]  w_sel_face;

    // The last sample of a block closes it.
    assign o_block_end = (AVG_EXP == 0) || (r_cnt == CNT_LAST);

    // Merge the lane findings: two still axes and exactly one face axis.
    always_comb begin
        w_still_cnt = 2'(i_flags[0].still) + 2'(i_flags[1].still) + 2'(i_flags[2].still);
        w_up_cnt    = 2'(i_flags[0].up) + 2'(i_flags[1].up) + 2'(i_flags[2].up);
        w_check_ok  = (w_still_cnt == 2'd2) && (w_up_cnt == 2'd1);
        if (i_flags[0].up) begin
            w_sel_face = i_flags[0].neg ? FACE_NEG_X : FACE_POS_X;
        end else if (i_flags[1].up) begin
            w_sel_face = i_flags[1].neg ? FACE_NEG_Y : FACE_POS_Y;
        end else begin
            w_sel_face = i_flags[2].neg ? FACE_NEG_Z : FACE_POS_Z;
        end
    end

    // Next state for one beat: the check timer runs before the throw timer.
    always_comb begin
        n_cnt         = r_cnt;
        n_check_ticks = r_check_ticks;
        n_throw_ticks = r_throw_ticks;
        n_check_armed = r_check_armed;
        n_throw_armed = r_throw_armed;
        n_face        = r_face;
        w_found       = 1'b0;
        case (i_mode)
            MODE_SAMPLE: begin
                n_cnt = o_block_end ? '0 : r_cnt + 1'b1;
            end
            MODE_BUTTON: begin
                n_throw_ticks = '0;
                n_throw_armed = 1'b1;
            end
            MODE_TICK: begin
                if (r_check_armed) begin
                    n_check_ticks = r_check_ticks + 1'b1;
                    if (n_check_ticks >= i_cfg.check_period) begin
                        n_check_ticks = '0;
                        if (w_check_ok) begin
                            w_found       = 1'b1;
                            n_check_armed = 1'b0;
                            n_face        = w_sel_face;
                        end
                    end
                end
                if (r_throw_armed) begin
                    n_throw_ticks = r_throw_ticks + 1'b1;
                    if (n_throw_ticks >= i_cfg.throw_time) begin
                        n_throw_armed = 1'b0;
                        n_check_armed = 1'b1;
                        n_check_ticks = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_check_ticks <= '0;
            r_throw_ticks <= '0;
            r_check_armed <= 1'b0;
            r_throw_armed <= 1'b0;
            r_face        <= FACE_MOVING;
        end else if (i_fire) begin
            r_cnt         <= n_cnt;
            r_check_ticks <= n_check_ticks;
            r_throw_ticks <= n_throw_ticks;
            r_check_armed <= n_check_armed;
            r_throw_armed <= n_throw_armed;
            r_face        <= n_face;
        end
    end

    // Result reports the state after this beat.
    always_comb begin
        o_result.face          = n_face;
        o_result.face_found    = w_found;
        o_result.checking      = n_check_armed;
        o_result.throw_running = n_throw_armed;
    end

endmodule

>>> hdl/dice_face_orientation_detector.sv
`timescale 1ns / 1ps
// An accepted beat's result is registered in the output register or in the skid stage.
// Throughput: one beat per cycle until the skid stage fills; the output register plus a
// one-entry skid stage keep input ready high while a single result waits to be taken.
// Reset: synchronous, active low; clears the sums, means, timers, face and output
// valids, and loads the configuration registers with their default values.
module dice_face_orientation_detector import dfod_pkg::*; #(
    parameter int AVG_EXP = AVG_EXP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dfod_in_if.sink               i_in,
    dfod_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                       r_cfg;
    logic                       w_fire;
    logic                       w_sample_en;
    logic                       w_block_end;
    logic signed [SAMPLE_W-1:0] w_sample [AXES];
    t_lane_flags                w_flags [AXES];
    t_result                    w_result;
    t_result                    r_out, r_skid;
    logic                       r_out_v, r_skid_v;
    logic                       w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.still_limit  <= STILL_LIMIT_RST;
            r_cfg.face_low     <= FACE_LOW_RST;
            r_cfg.face_high    <= FACE_HIGH_RST;
            r_cfg.throw_time   <= THROW_TIME_RST;
            r_cfg.check_period <= CHECK_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STILL_LIMIT:  r_cfg.still_limit  <= i_cfg_data[8:0];
                CFG_FACE_LOW:     r_cfg.face_low     <= i_cfg_data[8:0];
                CFG_FACE_HIGH:    r_cfg.face_high    <= i_cfg_data[9:0];
                CFG_THROW_TIME:   r_cfg.throw_time   <= i_cfg_data[TIMER_W-1:0];
                CFG_CHECK_PERIOD: r_cfg.check_period <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready  = !r_skid_v;
    assign w_fire      = i_in.valid && i_in.ready;
    assign w_sample_en = w_fire && (i_in.mode == MODE_SAMPLE);

    assign w_sample[0] = i_in.sample_x;
    assign w_sample[1] = i_in.sample_y;
    assign w_sample[2] = i_in.sample_z;

    // One averaging and classification lane per axis
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        dfod_axis_lane #(.AVG_EXP(AVG_EXP)) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_sample_en (w_sample_en),
            .i_block_end (w_block_end),
            .i_sample    (w_sample[g]),
            .i_cfg       (r_cfg),
            .o_flags     (w_flags[g])
        );
    end

    // Merge of the lane findings, timers and face latch
    dfod_ctrl #(.AVG_EXP(AVG_EXP)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_mode      (i_in.mode),
        .i_flags     (w_flags),
        .i_cfg       (r_cfg),
        .o_block_end (w_block_end),
        .o_result    (w_result)
    );

    // Output register with a one-entry skid stage behind it
    assign w_pop = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (w_pop) begin
                    r_skid_v <= 1'b0;
                end
            end else if (w_fire) begin
                if (r_out_v && !w_pop) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_fire) begin
            if (r_out_v && !w_pop) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.face          = r_out.face;
    assign o_out.face_found    = r_out.face_found;
    assign o_out.checking      = r_out.checking;
    assign o_out.throw_running = r_out.throw_running;

    // The skid stage only fills behind a held output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a beat while the output register is empty");

    // Every accepted beat leaves a result waiting on the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_v)
        else $error("accepted beat produced no pending result");

    // A found face is never the moving code.
    a_found_has_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.face_found) |-> (r_out.face != FACE_MOVING))
        else $error("face found reported with the moving code");

    // A successful check always disarms checking unless the throw timer re-armed it.
    a_found_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result.face_found && w_result.checking) |-> !w_result.throw_running)
        else $error("check success left checking armed without throw expiry");

endmodule

>>> tb/dfod_orientation_checker.sv
`timescale 1ns / 1ps

// Watches the input, output and configuration ports of the detector. It keeps its own
// copy of the averaging, timer and face state, predicts the report for every accepted
// input beat and compares each accepted output beat with the oldest prediction.
module dfod_orientation_checker import dfod_pkg::*; #(
    parameter int AVG_EXP = AVG_EXP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dfod_in_if                    i_in_ch,
    dfod_out_if                   i_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int SUM_W     = SAMPLE_W + AVG_EXP;
    localparam int BLOCK_LEN = 1 << AVG_EXP;

    // Shadow copy of the configuration and of the detector state
    t_cfg                       cfg_copy;
    logic signed [SUM_W-1:0]    acc [AXES];
    logic signed [SAMPLE_W-1:0] axis_mean [AXES];
    int                         blk_count;
    logic [FACE_W-1:0]          held_face;
    logic                       throw_on;
    logic                       check_on;
    logic [TIMER_W-1:0]         throw_cnt;
    logic [TIMER_W-1:0]         check_cnt;

    t_result face_reports_q[$];
    int      errs;

    // Advance the shadow state by one input beat and return the report it produces.
    function automatic t_result step_orientation(input logic [MODE_W-1:0] mode,
                                                 input logic signed [SAMPLE_W-1:0] sx,
                                                 input logic signed [SAMPLE_W-1:0] sy,
                                                 input logic signed [SAMPLE_W-1:0] sz);
        t_result                    r;
        logic signed [SAMPLE_W-1:0] s [AXES];
        logic                       found;
        int                         m;
        int                         n_still;
        int                         n_up;
        int                         up_axis;
        found = 1'b0;
        s[0] = sx;
        s[1] = sy;
        s[2] = sz;
        case (mode)
            MODE_SAMPLE: begin
                for (int a = 0; a < AXES; a++) begin
                    acc[a] = acc[a] + s[a];
                end
                blk_count++;
                // A full block updates the means; the shift rounds toward minus infinity.
                if (blk_count >= BLOCK_LEN) begin
                    for (int a = 0; a < AXES; a++) begin
                        axis_mean[a] = SAMPLE_W'(acc[a] >>> AVG_EXP);
                        acc[a] = '0;
                    end
                    blk_count = 0;
                end
            end
            MODE_BUTTON: begin
                throw_cnt = '0;
                throw_on  = 1'b1;
            end
            MODE_TICK: begin
                // The check timer runs first, so a check sees the state before this
                // tick's throw expiry.
                if (check_on) begin
                    check_cnt = check_cnt + 1'b1;
                    if (check_cnt >= cfg_copy.check_period) begin
                        check_cnt = '0;
                        n_still = 0;
                        n_up = 0;
                        up_axis = 0;
                        for (int a = 0; a < AXES; a++) begin
                            m = axis_mean[a];
                            if (m < 0) begin
                                m = -m;
                            end
                            if (m < int'(cfg_copy.still_limit)) begin
                                n_still++;
                            end else if (m > int'(cfg_copy.face_low) &&
                                         m < int'(cfg_copy.face_high)) begin
                                n_up++;
                                up_axis = a;
                            end
                        end
                        if (n_still == 2 && n_up == 1) begin
                            found    = 1'b1;
                            check_on = 1'b0;
                            case (up_axis)
                                0: held_face = (axis_mean[0] > 0) ? FACE_POS_X : FACE_NEG_X;
                                1: held_face = (axis_mean[1] > 0) ? FACE_POS_Y : FACE_NEG_Y;
                                default: held_face = (axis_mean[2] > 0) ? FACE_POS_Z
                                                                        : FACE_NEG_Z;
                            endcase
                        end
                    end
                end
                if (throw_on) begin
                    throw_cnt = throw_cnt + 1'b1;
                    if (throw_cnt >= cfg_copy.throw_time) begin
                        throw_on  = 1'b0;
                        check_on  = 1'b1;
                        check_cnt = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        r.face          = held_face;
        r.face_found    = found;
        r.checking      = check_on;
        r.throw_running = throw_on;
        return r;
    endfunction

    // Retire output beats, track register writes and predict input beats.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_copy = t_cfg'{STILL_LIMIT_RST, FACE_LOW_RST, FACE_HIGH_RST,
                              THROW_TIME_RST, CHECK_PERIOD_RST};
            for (int a = 0; a < AXES; a++) begin
                acc[a]       = '0;
                axis_mean[a] = '0;
            end
            blk_count = 0;
            held_face = FACE_MOVING;
            throw_on  = 1'b0;
            check_on  = 1'b0;
            throw_cnt = '0;
            check_cnt = '0;
            face_reports_q.delete();
            errs = 0;
        end else begin
            // A report leaves only after its beat has been registered, so compare
            // before predicting the beat taken at this same edge.
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (face_reports_q.size() == 0) begin
                    $error("report beat with no prediction waiting: face %0d",
                           i_out_ch.face);
                    errs++;
                end else begin
                    want = face_reports_q.pop_front();
                    if (i_out_ch.face !== want.face) begin
                        $error("face: expected %0d, actual %0d", want.face, i_out_ch.face);
                        errs++;
                    end
                    if (i_out_ch.face_found !== want.face_found) begin
                        $error("face_found: expected %0d, actual %0d",
                               want.face_found, i_out_ch.face_found);
                        errs++;
                    end
                    if (i_out_ch.checking !== want.checking) begin
                        $error("checking: expected %0d, actual %0d",
                               want.checking, i_out_ch.checking);
                        errs++;
                    end
                    if (i_out_ch.throw_running !== want.throw_running) begin
                        $error("throw_running: expected %0d, actual %0d",
                               want.throw_running, i_out_ch.throw_running);
                        errs++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STILL_LIMIT:  cfg_copy.still_limit  = i_cfg_data[8:0];
                    CFG_FACE_LOW:     cfg_copy.face_low     = i_cfg_data[8:0];
                    CFG_FACE_HIGH:    cfg_copy.face_high    = i_cfg_data[9:0];
                    CFG_THROW_TIME:   cfg_copy.throw_time   = i_cfg_data;
                    CFG_CHECK_PERIOD: cfg_copy.check_period = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                face_reports_q.push_back(step_orientation(i_in_ch.mode, i_in_ch.sample_x,
                                                          i_in_ch.sample_y,
                                                          i_in_ch.sample_z));
            end
        end
        o_fail_count <= errs;
        o_pending    <= face_reports_q.size();
    end

endmodule

>>> tb/dice_face_orientation_detector_test.sv
`timescale 1ns / 1ps

// Drives the detector with button, tick and sample beats. A short directed run walks a
// throw through to a latched face; random phases then replay throws with resting poses,
// motion, threshold probes and noise under several register settings and idle patterns.
module dice_face_orientation_detector_test;
    import dfod_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int BLOCK_LEN      = 1 << AVG_EXP_DEF;
    // Gaps and stalls are short random runs; this many quiet cycles means a hang.
    localparam int WATCHDOG_LIMIT = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   beats_sent = 0;
    t_cfg cur_cfg;
    int   pose [AXES];
    bit   pose_jitter;

    dfod_in_if  in_ch ();
    dfod_out_if out_ch ();

    dice_face_orientation_detector u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dfod_orientation_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_axis();
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_axis(input int v);
        if (v > 511) begin
            return 10'sd511;
        end
        if (v < -512) begin
            return -10'sd512;
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pose_sample(input int a);
        return clamp_axis(pose[a] + (pose_jitter ? int'($urandom_range(4)) - 2 : 0));
    endfunction

    // Thresholds around a random face window, with short timers so throws finish.
    function automatic t_cfg random_cfg();
        t_cfg c;
        int   lo;
        lo = $urandom_range(400, 60);
        c.still_limit  = 9'($urandom_range(60, 1));
        c.face_low     = 9'(lo);
        c.face_high    = 10'(lo + $urandom_range(80, 2));
        c.throw_time   = 16'($urandom_range(12, 1));
        c.check_period = 16'($urandom_range(6, 1));
        return c;
    endfunction

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic [MODE_W-1:0] m,
                             input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic signed [SAMPLE_W-1:0] z);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= m;
        in_ch.sample_x <= x;
        in_ch.sample_y <= y;
        in_ch.sample_z <= z;
        do @(posedge clk); while (!in_ch.ready);
        beats_sent++;
    endtask

    task automatic noise_beat();
        send_beat(MODE_W'($urandom_range(3)), rand_axis(), rand_axis(), rand_axis());
    endtask

    // Stop sending and wait until every predicted report has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input t_cfg c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_STILL_LIMIT;
        cfg_data <= CFG_DATA_W'(c.still_limit);
        @(posedge clk);
        cfg_idx  <= CFG_FACE_LOW;
        cfg_data <= CFG_DATA_W'(c.face_low);
        @(posedge clk);
        cfg_idx  <= CFG_FACE_HIGH;
        cfg_data <= CFG_DATA_W'(c.face_high);
        @(posedge clk);
        cfg_idx  <= CFG_THROW_TIME;
        cfg_data <= c.throw_time;
        @(posedge clk);
        cfg_idx  <= CFG_CHECK_PERIOD;
        cfg_data <= c.check_period;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_cfg = c;
    endtask

    // One throw: a button press, then a few rounds of one averaging block in some
    // pose followed by up to 40 ticks that may expire the throw timer and run checks.
    task automatic throw_session();
        int rounds;
        int ticks;
        int kind;
        int ax;
        int sgn;
        int lim;
        int lo;
        int hi;
        send_beat(MODE_BUTTON, rand_axis(), rand_axis(), rand_axis());
        rounds = $urandom_range(4, 1);
        repeat (rounds) begin
            kind = $urandom_range(9);
            ax   = $urandom_range(2);
            sgn  = ($urandom_range(1) == 1) ? 1 : -1;
            lim  = int'(cur_cfg.still_limit);
            lo   = int'(cur_cfg.face_low) + 1;
            hi   = int'(cur_cfg.face_high) - 1;
            for (int a = 0; a < AXES; a++) begin
                pose[a] = (lim > 1) ? int'($urandom_range(2 * lim - 2)) - (lim - 1) : 0;
            end
            if (kind >= 6 && kind < 8) begin
                // Still in motion: anything goes on every axis.
                for (int a = 0; a < AXES; a++) begin
                    pose[a] = int'($urandom_range(1023)) - 512;
                end
            end else begin
                pose[ax] = sgn * ((hi >= lo) ? int'($urandom_range(hi, lo))
                                             : int'($urandom_range(512)));
            end
            // Probe the edges of the face window and of the still band.
            if (kind >= 8) begin
                case ($urandom_range(5))
                    0: pose[ax] = sgn * (lo - 1);
                    1: pose[ax] = sgn * lo;
                    2: pose[ax] = sgn * hi;
                    3: pose[ax] = sgn * (hi + 1);
                    4: pose[(ax + 1) % AXES] = sgn * lim;
                    default: pose[(ax + 1) % AXES] = sgn * (lim - 1);
                endcase
            end
            pose_jitter = (kind < 8) && ($urandom_range(1) == 1);
            repeat (BLOCK_LEN) begin
                send_beat(MODE_SAMPLE, pose_sample(0), pose_sample(1), pose_sample(2));
            end
            ticks = int'(cur_cfg.throw_time) + 2 * int'(cur_cfg.check_period) + 2;
            if (ticks > 40) begin
                ticks = 40;
            end
            repeat ($urandom_range(ticks, 1)) begin
                if ($urandom_range(99) < 5) begin
                    noise_beat();
                end
                send_beat(MODE_TICK, rand_axis(), rand_axis(), rand_axis());
            end
        end
    endtask

    task automatic run_phase(input t_cfg c, input int idle, input int stall,
                             input int n_beats);
        int stop_at;
        settle();
        load_config(c);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                throw_session();
            end else begin
                repeat ($urandom_range(6, 1)) noise_beat();
            end
        end
    endtask

    initial begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_STILL_LIMIT;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.mode     <= MODE_SAMPLE;
        in_ch.sample_x <= '0;
        in_ch.sample_y <= '0;
        in_ch.sample_z <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed throw with default thresholds and a two-tick throw, one-tick period.
        load_config(t_cfg'{STILL_LIMIT_RST, FACE_LOW_RST, FACE_HIGH_RST, 16'd2, 16'd1});
        send_beat(MODE_UNUSED, SAMPLE_W'(511), SAMPLE_W'(-512), '0);
        send_beat(MODE_TICK, 0, 0, 0);
        // Full-scale samples whose block means are +x up, y and z near zero.
        for (int k = 0; k < BLOCK_LEN; k++) begin
            send_beat(MODE_SAMPLE, SAMPLE_W'((k % 2) ? 0 : 511),
                      SAMPLE_W'((k % 2) ? 511 : -512), SAMPLE_W'((k % 2) ? -512 : 511));
        end
        send_beat(MODE_BUTTON, 0, 0, 0);
        send_beat(MODE_TICK, 0, 0, 0);
        // Pressing again while the throw runs restarts it.
        send_beat(MODE_BUTTON, 0, 0, 0);
        send_beat(MODE_TICK, 0, 0, 0);
        send_beat(MODE_TICK, 0, 0, 0);
        // Button while checks are armed, then a check and a throw expiry on one tick each,
        // and a second latch over the held face.
        send_beat(MODE_BUTTON, 0, 0, 0);
        send_beat(MODE_TICK, 0, 0, 0);
        send_beat(MODE_TICK, 0, 0, 0);
        send_beat(MODE_TICK, 0, 0, 0);

        run_phase(random_cfg(), 0, 0, 420);
        run_phase(random_cfg(), 49, 0, 420);
        run_phase(random_cfg(), 0, 49, 420);
        run_phase(random_cfg(), 27, 27, 420);
        run_phase(t_cfg'{9'd0, 9'd0, 10'd0, 16'd0, 16'd0}, 27, 27, 80);
        run_phase(t_cfg'{9'd511, 9'd511, 10'd1023, 16'd65535, 16'd65535}, 0, 49, 80);
        run_phase(t_cfg'{STILL_LIMIT_RST, FACE_LOW_RST, FACE_HIGH_RST, 16'd0, 16'd0},
                  49, 0, 100);
        run_phase(t_cfg'{9'd60, 9'd255, 10'd512, 16'd1, 16'd1}, 0, 0, 100);
        settle();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/dfod_pkg.sv
hdl/dfod_in_if.sv
hdl/dfod_out_if.sv
hdl/dfod_axis_lane.sv
hdl/dfod_ctrl.sv
hdl/dice_face_orientation_detector.sv
tb/dfod_orientation_checker.sv
tb/dice_face_orientation_detector_test.sv
